FILE: hw/rtl/bgr565_pkg.sv
// shared types and constants for the bgr888 to rgb565 scaled plotter
// no dependencies; imported by the front, the back and the top level
package bgr565_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int BYTE_W      = 8;
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 16;
  localparam int WIDTH_CFG_W = 13;
  localparam int STRIDE_W    = 14;
  localparam int SCALE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_BITS   = 15;
  localparam int PROD_W      = COORD_W + SCALE_W;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [WIDTH_CFG_W-1:0] IMAGE_WIDTH_RST = WIDTH_CFG_W'(320);
  localparam logic [STRIDE_W-1:0]    ROW_STRIDE_RST  = STRIDE_W'(960);
  localparam logic [SCALE_W-1:0]     SCALE_ONE       = SCALE_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_ROW_STRIDE,
    REG_X_SCALE,
    REG_Y_SCALE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED,
    PH_PAD
  } byte_phase_t;

  typedef struct packed {
    logic [WIDTH_CFG_W-1:0] image_width;
    logic [STRIDE_W-1:0]    row_stride;
  } geom_cfg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
  } scale_cfg_t;

  // pixel as gathered by the front, before scaling
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] color;
  } pix_rec_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic [COLOR_W-1:0] pixel_color;
  } out_rec_t;

endpackage

FILE: hw/rtl/bgr565_fifo.sv
// small register queue with count, used between front and back and at the output
// depends on nothing but its parameters
module bgr565_fifo #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/bgr565_front.sv
// front part: takes pixel bytes, tracks byte phase, column, row and row stride,
// and queues each finished pixel; depends on bgr565_pkg
module bgr565_front
  import bgr565_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [BYTE_W-1:0] in_pixel_byte,
  input  logic              in_frame_start,
  output logic              in_full,
  input  geom_cfg_t         geom,
  input  logic              q_full,
  output logic              q_push,
  output pix_rec_t          q_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  byte_phase_t         phase_r, phase_nxt, phase_c;
  logic [COLOR_W-1:0]  partial_r, partial_nxt, partial_c;
  logic [STRIDE_W-1:0] rbc_r, rbc_nxt, rbc_c;
  logic [COL_W-1:0]    col_r, col_nxt, col_c;
  logic [ROW_W-1:0]    row_r, row_nxt, row_c;

  logic [COL_W:0]      width_eff;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [STRIDE_W:0]   rbc_inc;
  logic [COLOR_W-1:0]  color_c;
  logic                accept;
  logic                emit;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  // widths above the supported maximum act as the maximum
  assign width_eff = (geom.image_width > WIDTH_CFG_W'(MAX_WIDTH)) ?
                     (COL_W+1)'(MAX_WIDTH) : geom.image_width[COL_W:0];

  // frame start clears position before the byte is used
  assign phase_c   = in_frame_start ? PH_BLUE : phase_r;
  assign partial_c = in_frame_start ? '0 : partial_r;
  assign rbc_c     = in_frame_start ? '0 : rbc_r;
  assign col_c     = in_frame_start ? '0 : col_r;
  assign row_c     = in_frame_start ? '0 : row_r;

  assign col_inc = {1'b0, col_c} + 1'b1;
  assign row_inc = {1'b0, row_c} + 1'b1;
  assign rbc_inc = {1'b0, rbc_c} + 1'b1;
  assign color_c = {in_pixel_byte[7:3], partial_c[10:0]};

  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    rbc_nxt     = rbc_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    emit        = 1'b0;
    if (accept) begin
      phase_nxt   = phase_c;
      partial_nxt = partial_c;
      col_nxt     = col_c;
      row_nxt     = row_c;
      if (phase_c != PH_PAD && {1'b0, col_c} < width_eff) begin
        case (phase_c)
          PH_BLUE: begin
            partial_nxt = {11'd0, in_pixel_byte[7:3]};
            phase_nxt   = PH_GREEN;
          end
          PH_GREEN: begin
            partial_nxt = partial_c | {5'd0, in_pixel_byte[7:2], 5'd0};
            phase_nxt   = PH_RED;
          end
          PH_RED: begin
            emit        = 1'b1;
            partial_nxt = color_c;
            phase_nxt   = (col_inc >= width_eff) ? PH_PAD : PH_BLUE;
            col_nxt     = col_inc[COL_W-1:0];
          end
          default: begin
            phase_nxt = PH_PAD;
          end
        endcase
      end
      // row end restarts phase and column regardless of the pixel work
      if (rbc_inc >= {1'b0, geom.row_stride}) begin
        rbc_nxt     = '0;
        col_nxt     = '0;
        phase_nxt   = PH_BLUE;
        partial_nxt = '0;
        row_nxt     = (row_inc >= (ROW_W+1)'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        rbc_nxt = rbc_inc[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BLUE;
      partial_r <= '0;
      rbc_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      rbc_r     <= rbc_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

  assign q_push       = emit;
  assign q_data.col   = COORD_W'(col_c);
  assign q_data.row   = COORD_W'(row_c);
  assign q_data.color = color_c;

endmodule

FILE: hw/rtl/bgr565_back.sv
// back part: scales queued pixel coordinates by the q1.15 factors, rounds half up
// and saturates; depends on bgr565_pkg
module bgr565_back
  import bgr565_pkg::*;
#(
  parameter int OUT_DEPTH = bgr565_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scale_cfg_t                     scale,
  input  logic                           q_empty,
  input  pix_rec_t                       q_data,
  output logic                           q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] o_count,
  output logic                           o_push,
  output out_rec_t                       o_data
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic                s1_v_r;
  logic [PROD_W-1:0]   x_prod_r, y_prod_r;
  logic [COLOR_W-1:0]  color_r;
  logic [CNT_W:0]      committed;

  function automatic logic [COORD_W-1:0] round_sat(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0]            sum;
    logic [PROD_W-FRAC_BITS:0]  q;
    sum = {1'b0, prod} + ROUND_HALF;
    q   = sum[PROD_W:FRAC_BITS];
    return (q > (PROD_W-FRAC_BITS+1)'({COORD_W{1'b1}})) ? {COORD_W{1'b1}} : q[COORD_W-1:0];
  endfunction

  // only take a pixel when the output queue has room for it and the one in flight
  assign committed = {1'b0, o_count} + (CNT_W+1)'(s1_v_r);
  assign q_pop     = !q_empty && (committed < (CNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_prod_r <= q_data.col * scale.x_scale;
      y_prod_r <= q_data.row * scale.y_scale;
      color_r  <= q_data.color;
    end
  end

  assign o_push             = s1_v_r;
  assign o_data.screen_x    = round_sat(x_prod_r);
  assign o_data.screen_y    = round_sat(y_prod_r);
  assign o_data.pixel_color = color_r;

endmodule

FILE: hw/rtl/bgr888_to_rgb565_scaled_plotter.sv
// top level of the bgr888 to rgb565 scaled plotter: config registers, front,
// middle queue, back and output queue; depends on bgr565_pkg and all bgr565_ modules
//
// usage: bmp pixel-array bytes enter one per request (push while full is low), in
// blue, green, red order, with frame_start on the first byte of a frame. every red
// byte that completes a pixel inside the configured width yields one result request
// with the scaled column, scaled row and rgb565 color; padding bytes yield nothing.
// the result side is a queue: a result is shown while empty is low and leaves on pop.
// a result passes the middle queue, then the multiplier register, then the output
// queue, before it is visible. throughput: one byte per cycle while full is low;
// at most one result per three bytes; the back takes one per cycle while the output
// queue has room. when the receiver stalls, the four-entry output queue fills, the
// back stops draining the two-entry middle queue, and full rises once that fills.
// reset clears phase, counters, queues and loads width 320, stride 960, scales one.
// config writes (cfg_ready is always high) take effect at once; write only when idle.
module bgr888_to_rgb565_scaled_plotter
  import bgr565_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [BYTE_W-1:0]     in_pixel_byte,
  input  logic                  in_frame_start,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COORD_W-1:0]    out_screen_x,
  output logic [COORD_W-1:0]    out_screen_y,
  output logic [COLOR_W-1:0]    out_pixel_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  geom_cfg_t  geom_r, geom_nxt;
  scale_cfg_t scale_r, scale_nxt;

  logic        mid_push, mid_full, mid_pop, mid_empty;
  pix_rec_t    mid_wdata, mid_rdata;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

  logic        oq_push, oq_full;
  out_rec_t    oq_wdata, oq_rdata;
  logic [OCNT_W-1:0] oq_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    geom_nxt  = geom_r;
    scale_nxt = scale_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: geom_nxt.image_width = cfg_data[WIDTH_CFG_W-1:0];
        REG_ROW_STRIDE:  geom_nxt.row_stride  = cfg_data[STRIDE_W-1:0];
        REG_X_SCALE:     scale_nxt.x_scale    = cfg_data[SCALE_W-1:0];
        REG_Y_SCALE:     scale_nxt.y_scale    = cfg_data[SCALE_W-1:0];
        default: begin
          geom_nxt = geom_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.image_width <= IMAGE_WIDTH_RST;
      geom_r.row_stride  <= ROW_STRIDE_RST;
      scale_r.x_scale    <= SCALE_ONE;
      scale_r.y_scale    <= SCALE_ONE;
    end else begin
      geom_r  <= geom_nxt;
      scale_r <= scale_nxt;
    end
  end

  bgr565_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_pixel_byte  (in_pixel_byte),
    .in_frame_start (in_frame_start),
    .in_full        (in_full),
    .geom           (geom_r),
    .q_full         (mid_full),
    .q_push         (mid_push),
    .q_data         (mid_wdata)
  );

  bgr565_fifo #(
    .WIDTH ($bits(pix_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_wdata),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_rdata),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  bgr565_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .scale   (scale_r),
    .q_empty (mid_empty),
    .q_data  (mid_rdata),
    .q_pop   (mid_pop),
    .o_count (oq_count),
    .o_push  (oq_push),
    .o_data  (oq_wdata)
  );

  bgr565_fifo #(
    .WIDTH ($bits(out_rec_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_wdata),
    .full      (oq_full),
    .pop       (out_pop),
    .pop_data  (oq_rdata),
    .empty     (out_empty),
    .count     (oq_count)
  );

  assign out_screen_x    = oq_rdata.screen_x;
  assign out_screen_y    = oq_rdata.screen_y;
  assign out_pixel_color = oq_rdata.pixel_color;

  // the back must never push a result the output queue cannot hold
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("output queue overflow");

  // a pixel enters the middle queue only on an accepted byte
  a_mid_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (in_push && !in_full))
    else $error("pixel queued without an accepted byte");

  // every pixel taken from the middle queue reaches the output queue next cycle
  a_pop_then_push: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> oq_push)
    else $error("pixel lost between middle and output queue");

  // middle queue occupancy never exceeds its depth
  a_mid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_count <= ($bits(mid_count))'(MID_DEPTH))
    else $error("middle queue count out of range");

endmodule
